// ===== hw/rtl/srp_pkg.sv =====
`timescale 1ns / 1ps
package srp_pkg;
  localparam int DEF_MAX_SHELVES = 512;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_BIN_WIDTH    = 2'd0;
  localparam logic [1:0] REG_BIN_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ALLOW_ROTATE = 2'd2;
  localparam logic [1:0] REG_COLUMN_MODE  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item, clear store on first item
    logic scan_rd;   // issue read of shelf at scan index
    logic scan_eval; // evaluate read data
    logic commit;    // update store and emit result
  } srp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last; // scan index reached the shelf count
  } srp_sts_t;
endpackage

// ===== hw/rtl/srp_ctrl.sv =====
`timescale 1ns / 1ps
module srp_ctrl
  import srp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  srp_sts_t sts,
  output srp_cmd_t cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state, state_next;
  logic       eval_pend, eval_pend_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eval_pend <= 1'b0;
    end else begin
      state <= state_next;
      eval_pend <= eval_pend_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    eval_pend_next = 1'b0;
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_eval = eval_pend;
        if (sts.scan_last) begin
          if (!eval_pend) state_next = ST_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          eval_pend_next = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/srp_datapath.sv =====
`timescale 1ns / 1ps
module srp_datapath
  import srp_pkg::*;
#(
  parameter int MAX_SHELVES = DEF_MAX_SHELVES
) (
  input  logic        clk,
  input  logic        rst,
  input  srp_cmd_t    cmd,
  output srp_sts_t    sts,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic [15:0] item_width,
  input  logic [15:0] item_height,
  input  logic [31:0] item_value,
  input  logic [15:0] item_tag,
  input  logic        first_item,
  output logic        done,
  output logic        placed,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic        rotated,
  output logic [15:0] tag_out,
  output logic [47:0] total_value
);
  localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CW = $clog2(MAX_SHELVES + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_SHELVES);

  // configuration registers
  logic [15:0] bin_width, bin_height;
  logic        rotate_en, column_mode;
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= 16'd1024;
      bin_height <= 16'd1024;
      rotate_en <= 1'b0;
      column_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIN_WIDTH:    bin_width <= cfg_data[15:0];
        REG_BIN_HEIGHT:   bin_height <= cfg_data[15:0];
        REG_ALLOW_ROTATE: rotate_en <= cfg_data[0];
        REG_COLUMN_MODE:  column_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shelf store: origin, thickness, fill in one word
  logic [48:0] mem [MAX_SHELVES];
  logic [48:0] rd_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [48:0] wr_data;
  logic [CW-1:0] scan_idx;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.scan_rd) rd_data <= mem[scan_idx[AW-1:0]];
  end

  // item registers
  logic [16:0] a0, c0, a1, c1, along_len, across_len;
  logic [31:0] val;
  logic [15:0] tag;
  logic        rot_ok, col;
  logic [CW-1:0] shelf_count;
  logic [16:0] next_edge;
  logic [47:0] value_sum;

  // best candidate tracking
  logic        found, best_r;
  logic [17:0] best_left;
  logic [15:0] best_org;
  logic [15:0] best_th;
  logic [AW-1:0] best_idx, eval_idx;
  logic [16:0] best_fill;

  // evaluation of one read shelf
  logic [15:0] s_org, s_th;
  logic [16:0] s_fill;
  logic signed [18:0] room;
  logic        fit0, fit1, take0, take1;
  logic [17:0] left0, left1;
  always_comb begin
    s_org = rd_data[48:33];
    s_th = rd_data[32:17];
    s_fill = rd_data[16:0];
    room = $signed({2'b0, along_len}) - $signed({2'b0, s_fill});
    fit0 = ($signed({2'b0, a0}) <= room) && (c0 <= {1'b0, s_th});
    fit1 = rot_ok && ($signed({2'b0, a1}) <= room) && (c1 <= {1'b0, s_th});
    left0 = 18'(room - $signed({2'b0, a0}));
    left1 = 18'(room - $signed({2'b0, a1}));
    take0 = fit0 && (!found || left0 < best_left ||
                     (left0 == best_left && s_org < best_org));
    take1 = fit1 && !(take0 && left0 <= left1) &&
            (take0 || !found || left1 < best_left ||
             (left1 == best_left && s_org < best_org));
  end

  // new shelf choice
  logic nf0, nf1, pick_r, pick_ok;
  logic [16:0] pa, pc;
  always_comb begin
    nf0 = (a0 <= along_len) && ({1'b0, next_edge} + {1'b0, c0} <= {1'b0, across_len});
    nf1 = rot_ok && (a1 <= along_len) &&
          ({1'b0, next_edge} + {1'b0, c1} <= {1'b0, across_len});
    pick_ok = (nf0 || nf1) && (shelf_count < CMAX);
    pick_r = nf1 && (!nf0 || c1 < c0 || (c1 == c0 && a1 > a0));
    pa = pick_r ? a1 : a0;
    pc = pick_r ? c1 : c0;
  end

  assign sts.scan_last = (scan_idx == shelf_count);

  // write port and result values
  logic        res_placed;
  logic [15:0] res_x, res_y;
  logic [47:0] sum_add;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = best_idx;
    wr_data = '0;
    res_placed = 1'b0;
    res_x = '0;
    res_y = '0;
    if (found) begin
      wr_en = cmd.commit;
      wr_data = {best_org, best_th, 17'(best_fill + (best_r ? a1 : a0))};
      res_placed = 1'b1;
      res_x = col ? best_org : best_fill[15:0];
      res_y = col ? best_fill[15:0] : best_org;
    end else if (pick_ok) begin
      wr_en = cmd.commit;
      wr_addr = shelf_count[AW-1:0];
      wr_data = {next_edge[15:0], pc[15:0], pa};
      res_placed = 1'b1;
      res_x = col ? next_edge[15:0] : 16'd0;
      res_y = col ? 16'd0 : next_edge[15:0];
    end
    sum_add = value_sum + 48'(val);
    if (sum_add < value_sum) sum_add = SUM_MAX;
  end

  // sequencing of item, scan and commit
  always_ff @(posedge clk) begin
    if (rst) begin
      shelf_count <= '0;
      next_edge <= '0;
      value_sum <= '0;
      done <= 1'b0;
      scan_idx <= '0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        col <= column_mode;
        rot_ok <= rotate_en && (item_width != item_height);
        a0 <= {1'b0, column_mode ? item_height : item_width};
        c0 <= {1'b0, column_mode ? item_width : item_height};
        a1 <= {1'b0, column_mode ? item_width : item_height};
        c1 <= {1'b0, column_mode ? item_height : item_width};
        along_len <= {1'b0, column_mode ? bin_height : bin_width};
        across_len <= {1'b0, column_mode ? bin_width : bin_height};
        val <= item_value;
        tag <= item_tag;
        scan_idx <= '0;
        found <= 1'b0;
        if (first_item) begin
          shelf_count <= '0;
          next_edge <= '0;
          value_sum <= '0;
        end
      end
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
        eval_idx <= scan_idx[AW-1:0];
      end
      if (cmd.scan_eval && (take0 || take1)) begin
        found <= 1'b1;
        best_r <= take1;
        best_left <= take1 ? left1 : left0;
        best_org <= s_org;
        best_idx <= eval_idx;
        best_fill <= s_fill;
        best_th <= s_th;
      end
      if (cmd.commit) begin
        done <= 1'b1;
        placed <= res_placed;
        pos_x <= res_x;
        pos_y <= res_y;
        rotated <= res_placed && (found ? best_r : pick_r);
        tag_out <= tag;
        if (res_placed) begin
          value_sum <= sum_add;
          total_value <= sum_add;
        end else begin
          total_value <= value_sum;
        end
        if (!found && pick_ok) begin
          shelf_count <= shelf_count + 1'b1;
          next_edge <= 17'(next_edge + pc);
        end
      end
    end
  end
endmodule

// ===== hw/rtl/shelf_rectangle_packer.sv =====
`timescale 1ns / 1ps
// Shelf best-fit rectangle packer. Pulse start while busy is low to hand in
// one item; busy stays high while the open shelves are scanned and the result
// is committed, and the result appears for a single cycle with done high in
// the first cycle with busy low again; the receiver cannot stall it. The open
// shelves are read from the shelf memory one per cycle and each read is
// checked in the cycle after, then the DONE state commits. A new item may be
// handed in during the result cycle.
// Configuration writes are always ready and are meant only while not busy.
module shelf_rectangle_packer
  import srp_pkg::*;
#(
  parameter int MAX_SHELVES = DEF_MAX_SHELVES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [15:0] item_width,
  input  logic [15:0] item_height,
  input  logic [31:0] item_value,
  input  logic [15:0] item_tag,
  input  logic        first_item,
  output logic        done,
  output logic        placed,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic        rotated,
  output logic [15:0] tag_out,
  output logic [47:0] total_value
);
  srp_cmd_t cmd;
  srp_sts_t sts;

  assign cfg_ready = 1'b1;

  srp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  srp_datapath #(.MAX_SHELVES(MAX_SHELVES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_index(cfg_index), .cfg_we(cfg_valid), .cfg_data(cfg_data),
    .item_width(item_width), .item_height(item_height),
    .item_value(item_value), .item_tag(item_tag), .first_item(first_item),
    .done(done), .placed(placed), .pos_x(pos_x), .pos_y(pos_y),
    .rotated(rotated), .tag_out(tag_out), .total_value(total_value)
  );
endmodule
